// ===== src/ols_pkg.sv =====
// Shared types and codes for the ordered list store.
package ols_pkg;

    // Operation carried by each input transaction.
    typedef enum logic [1:0] {
        KIND_APPEND = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_CLEAR  = 2'd3
    } kind_t;

    // Result status codes.
    typedef logic [1:0] status_t;
    localparam status_t ST_DONE      = 2'd0;
    localparam status_t ST_NOT_FOUND = 2'd1;
    localparam status_t ST_FULL      = 2'd2;

    // Field widths of the stream payloads.
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned POS_W    = 5;
    localparam int unsigned LEN_W    = 5;
    localparam int unsigned IN_DW    = 40;
    localparam int unsigned OUT_DW   = 8;
    localparam int unsigned KIND_W   = 2;

endpackage

// ===== src/ordered_list_store_unit.sv =====
// Ordered list of signed 32-bit values held in a single-port-write, registered-read memory.
//
//  Channel | Direction | Signals                        | Contents
//  --------+-----------+--------------------------------+------------------------------------
//  s_*     | input     | s_tvalid s_tready s_tdata s_tuser | operation, value, insert position
//  m_*     | output    | m_tvalid m_tready m_tdata      | status and length after operation
//
// Append and clear need only decode and response; insert at position p moves entries
// p..length-1 up, last first, then writes the value; remove scans from index 0 to the
// first match, then moves each later entry down. Entries move one per cycle through the
// registered read. One transaction is worked on at a time; a finished result waits in the
// output register and stalls only the final step. Reset empties the list at once.
module ordered_list_store_unit #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // s_tdata fields from bit 0: value[31:0], position[36:32], zero fill [39:37]
    input  logic [ols_pkg::IN_DW-1:0]      s_tdata,
    // s_tuser fields from bit 0: kind[1:0]
    input  logic [ols_pkg::KIND_W-1:0]     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata fields from bit 0: status[1:0], length[6:2], zero fill [7]
    output logic [ols_pkg::OUT_DW-1:0]     m_tdata
);
    import ols_pkg::*;

    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW   = $clog2(DEPTH + 1);
    localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_INS_SHIFT = 6'b000010,
        S_INS_PUT   = 6'b000100,
        S_SCAN      = 6'b001000,
        S_DEL_SHIFT = 6'b010000,
        S_RESP      = 6'b100000
    } state_t;

    state_t                state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    status_t               status_reg, status_next;
    logic [AW-1:0]         rd_idx_reg, rd_idx_next;
    logic [AW-1:0]         pos_reg, pos_next;
    logic [VALUE_W-1:0]    value_reg, value_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [OUT_DW-1:0]     m_tdata_reg, m_tdata_next;

    // List storage with registered read data.
    logic [VALUE_W-1:0]    mem [DEPTH];
    logic [VALUE_W-1:0]    rdata_reg;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [VALUE_W-1:0]    wr_data;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;

    // Decoded input fields and list status.
    logic [VALUE_W-1:0]    in_value;
    logic [POS_W-1:0]      in_pos;
    kind_t                 in_kind;
    logic                  full;
    logic                  at_end;
    logic [AW-1:0]         last_idx;
    logic                  accept;

    assign in_value = s_tdata[VALUE_W-1:0];
    assign in_pos   = s_tdata[VALUE_W+POS_W-1:VALUE_W];
    assign in_kind  = kind_t'(s_tuser);
    assign full     = (count_reg == CW'(DEPTH));
    assign at_end   = (CMPW'(in_pos) >= CMPW'(count_reg));
    assign last_idx = AW'(count_reg - CW'(1));
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Memory port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Sequencer: decode, shift entries one per cycle, and deliver the result.
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        status_next   = status_reg;
        rd_idx_next   = rd_idx_reg;
        pos_next      = pos_reg;
        value_next    = value_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        wr_en         = 1'b0;
        wr_addr       = '0;
        wr_data       = value_reg;
        rd_en         = 1'b0;
        rd_addr       = '0;

        // The output register empties when its transaction completes.
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    value_next  = in_value;
                    status_next = ST_DONE;
                    state_next  = S_RESP;
                    case (in_kind)
                        KIND_APPEND, KIND_INSERT:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else if (in_kind == KIND_APPEND || at_end)
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = AW'(count_reg);
                                wr_data    = in_value;
                                count_next = count_reg + CW'(1);
                            end
                            else
                            begin
                                // Move the tail up, starting from the last entry.
                                pos_next    = AW'(in_pos);
                                rd_en       = 1'b1;
                                rd_addr     = last_idx;
                                rd_idx_next = last_idx;
                                state_next  = S_INS_SHIFT;
                            end
                        end
                        KIND_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_NOT_FOUND;
                            end
                            else
                            begin
                                rd_en       = 1'b1;
                                rd_addr     = '0;
                                rd_idx_next = '0;
                                state_next  = S_SCAN;
                            end
                        end
                        default:
                        begin
                            count_next = '0;
                        end
                    endcase
                end
            end

            S_INS_SHIFT:
            begin
                wr_en   = 1'b1;
                wr_addr = rd_idx_reg + AW'(1);
                wr_data = rdata_reg;
                if (rd_idx_reg == pos_reg)
                begin
                    state_next = S_INS_PUT;
                end
                else
                begin
                    rd_en       = 1'b1;
                    rd_addr     = rd_idx_reg - AW'(1);
                    rd_idx_next = rd_idx_reg - AW'(1);
                end
            end

            S_INS_PUT:
            begin
                wr_en      = 1'b1;
                wr_addr    = pos_reg;
                wr_data    = value_reg;
                count_next = count_reg + CW'(1);
                state_next = S_RESP;
            end

            S_SCAN:
            begin
                if (rdata_reg == value_reg)
                begin
                    if (rd_idx_reg == last_idx)
                    begin
                        count_next = count_reg - CW'(1);
                        state_next = S_RESP;
                    end
                    else
                    begin
                        rd_en       = 1'b1;
                        rd_addr     = rd_idx_reg + AW'(1);
                        rd_idx_next = rd_idx_reg + AW'(1);
                        state_next  = S_DEL_SHIFT;
                    end
                end
                else if (rd_idx_reg == last_idx)
                begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_RESP;
                end
                else
                begin
                    rd_en       = 1'b1;
                    rd_addr     = rd_idx_reg + AW'(1);
                    rd_idx_next = rd_idx_reg + AW'(1);
                end
            end

            S_DEL_SHIFT:
            begin
                // Move each later entry down over the removed one.
                wr_en   = 1'b1;
                wr_addr = rd_idx_reg - AW'(1);
                wr_data = rdata_reg;
                if (rd_idx_reg == last_idx)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_RESP;
                end
                else
                begin
                    rd_en       = 1'b1;
                    rd_addr     = rd_idx_reg + AW'(1);
                    rd_idx_next = rd_idx_reg + AW'(1);
                end
            end

            S_RESP:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, LEN_W'(count_reg), status_reg};
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Working and payload registers.
    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        rd_idx_reg  <= rd_idx_next;
        pos_reg     <= pos_next;
        value_reg   <= value_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== dv/ordered_list_store_unit_tb.sv =====
// Self-checking testbench for the ordered list store: directed and random list operations.
module ordered_list_store_unit_tb;
    import ols_pkg::*;

    localparam int unsigned LIST_DEPTH = 16;
    localparam int unsigned NUM_RANDOM = 1325;

    // One list operation as queued for the driver; drain holds it back until all results are in.
    typedef struct packed {
        logic             drain;
        kind_t            kind;
        logic [POS_W-1:0] position;
        logic [31:0]      value;
    } list_op_t;

    // Status and length expected for one transaction.
    typedef struct packed {
        status_t          status;
        logic [LEN_W-1:0] length;
    } list_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    // s_tdata fields from bit 0: value[31:0], position[36:32], zero fill [39:37]
    logic [IN_DW-1:0] s_tdata = '0;
    // s_tuser fields from bit 0: kind[1:0]
    logic [KIND_W-1:0] s_tuser = KIND_APPEND;
    logic m_tvalid;
    logic m_tready = 1'b0;
    // m_tdata fields from bit 0: status[1:0], length[6:2], zero fill [7]
    logic [OUT_DW-1:0] m_tdata;

    list_op_t     pending_ops[$];
    list_result_t expected_results[$];

    // Shadow copy of the list contents and fill level.
    logic [31:0] held[LIST_DEPTH];
    int          held_cnt = 0;

    int err_cnt = 0;
    int total_ops = 0;
    int accepted_cnt = 0;
    int kind_cnt[4] = '{0, 0, 0, 0};
    int full_cnt = 0;
    int miss_cnt = 0;
    int max_len = 0;

    // Driver state.
    list_op_t cur_op;
    bit       nxt_valid;
    int       send_gap = 0;
    int       send_run = 0;

    // Monitor state.
    list_result_t exp_res;
    int           rcv_gap = 0;
    int           rcv_run = 0;

    ordered_list_store_unit #(
        .DEPTH(LIST_DEPTH)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #5 clk = ~clk;

    // Mostly short gaps, now and then a long one.
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 30);
    endfunction

    function automatic list_op_t make_op(kind_t kind, logic [31:0] value,
                                         logic [POS_W-1:0] position);
        list_op_t op;
        op.drain    = 1'b0;
        op.kind     = kind;
        op.value    = value;
        op.position = position;
        return op;
    endfunction

    // Apply one operation to the shadow list and queue the result it must produce.
    task automatic apply_list_op(input list_op_t op);
        list_result_t res;
        int           idx;
        int           hit;
        int           i;
        res.status = ST_DONE;
        case (op.kind)
            KIND_APPEND, KIND_INSERT:
            begin
                if (held_cnt >= LIST_DEPTH)
                begin
                    res.status = ST_FULL;
                    full_cnt++;
                end
                else
                begin
                    // A position at or past the tail appends.
                    if (op.kind == KIND_APPEND || op.position >= held_cnt)
                        idx = held_cnt;
                    else
                        idx = op.position;
                    for (i = held_cnt; i > idx; i--)
                        held[i] = held[i - 1];
                    held[idx] = op.value;
                    held_cnt++;
                end
            end
            KIND_REMOVE:
            begin
                hit = -1;
                for (i = 0; i < held_cnt; i++)
                    if (hit < 0 && held[i] == op.value)
                        hit = i;
                if (hit < 0)
                begin
                    res.status = ST_NOT_FOUND;
                    miss_cnt++;
                end
                else
                begin
                    for (i = hit; i < held_cnt - 1; i++)
                        held[i] = held[i + 1];
                    held_cnt--;
                end
            end
            default:
                held_cnt = 0;
        endcase
        res.length = held_cnt[LEN_W-1:0];
        if (held_cnt > max_len)
            max_len = held_cnt;
        kind_cnt[op.kind]++;
        expected_results.push_back(res);
    endtask

    // Driver: predicts on each accepted transaction and feeds the next one after a random gap.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= KIND_APPEND;
        end
        else
        begin
            nxt_valid = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                apply_list_op(cur_op);
                accepted_cnt++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (pending_ops.size() > 0 &&
                         !(pending_ops[0].drain && expected_results.size() != 0))
                begin
                    cur_op = pending_ops.pop_front();
                    s_tdata <= {3'b000, cur_op.position, cur_op.value};
                    s_tuser <= cur_op.kind;
                    nxt_valid = 1'b1;
                    if (send_run > 0)
                    begin
                        send_run--;
                        send_gap = 0;
                    end
                    else
                    begin
                        send_gap = draw_gap();
                        if ($urandom_range(0, 49) == 0)
                            send_run = $urandom_range(15, 60);
                    end
                end
            end
            s_tvalid <= nxt_valid;
        end
    end

    // Monitor: checks each result against the oldest expectation and stalls at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, got status %0d length %0d",
                             $time, m_tdata[1:0], m_tdata[6:2]);
                    err_cnt++;
                end
                else
                begin
                    exp_res = expected_results.pop_front();
                    if (m_tdata[1:0] !== exp_res.status)
                    begin
                        $display("%0t: status mismatch: expected %0d, got %0d",
                                 $time, exp_res.status, m_tdata[1:0]);
                        err_cnt++;
                    end
                    if (m_tdata[6:2] !== exp_res.length)
                    begin
                        $display("%0t: length mismatch: expected %0d, got %0d",
                                 $time, exp_res.length, m_tdata[6:2]);
                        err_cnt++;
                    end
                end
                if (rcv_run > 0)
                begin
                    rcv_run--;
                    rcv_gap = 0;
                end
                else
                begin
                    rcv_gap = draw_gap();
                    if ($urandom_range(0, 49) == 0)
                        rcv_run = $urandom_range(15, 60);
                end
            end
            if (rcv_gap > 0)
            begin
                rcv_gap--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        logic [31:0] pool[8];
        list_op_t    op;
        int          r;
        int          i;

        // Directed part: empty-list cases, extremes, inserts past the end, full list.
        pending_ops.push_back(make_op(KIND_REMOVE, 32'h0000_0000, 5'd0));
        pending_ops.push_back(make_op(KIND_CLEAR, 32'hFFFF_FFFF, 5'd31));
        pending_ops.push_back(make_op(KIND_INSERT, 32'h1234_5678, 5'd5));
        pending_ops.push_back(make_op(KIND_APPEND, 32'h7FFF_FFFF, 5'd0));
        pending_ops.push_back(make_op(KIND_APPEND, 32'h8000_0000, 5'd16));
        pending_ops.push_back(make_op(KIND_INSERT, 32'hFFFF_FFFF, 5'd0));
        pending_ops.push_back(make_op(KIND_INSERT, 32'h0000_0000, 5'd1));
        pending_ops.push_back(make_op(KIND_INSERT, 32'hAAAA_AAAA, 5'd31));
        pending_ops.push_back(make_op(KIND_REMOVE, 32'h0000_3039, 5'd0));
        pending_ops.push_back(make_op(KIND_REMOVE, 32'h8000_0000, 5'd0));
        pending_ops.push_back(make_op(KIND_REMOVE, 32'hFFFF_FFFF, 5'd0));
        // Fill to capacity with repeated values so removal must pick the first match.
        for (i = 0; i < 12; i++)
            pending_ops.push_back(make_op(kind_t'(i[0] ? KIND_APPEND : KIND_INSERT),
                                          i[0] ? 32'h5555_5555 : 32'h0000_0007,
                                          5'(i + 2)));
        pending_ops.push_back(make_op(KIND_APPEND, 32'h0BAD_0BAD, 5'd0));
        pending_ops.push_back(make_op(KIND_INSERT, 32'h0BAD_0BAD, 5'd16));
        pending_ops.push_back(make_op(KIND_REMOVE, 32'h0000_0007, 5'd0));
        pending_ops.push_back(make_op(KIND_CLEAR, 32'h0000_0000, 5'd0));

        // Random part: values mostly from a small pool so removals find their targets.
        pool[0] = 32'h8000_0000;
        pool[1] = 32'h7FFF_FFFF;
        pool[2] = 32'h0000_0000;
        pool[3] = 32'hFFFF_FFFF;
        for (i = 4; i < 8; i++)
            pool[i] = $urandom;
        for (i = 0; i < NUM_RANDOM; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 32)
                op.kind = KIND_APPEND;
            else if (r < 62)
                op.kind = KIND_INSERT;
            else if (r < 94)
                op.kind = KIND_REMOVE;
            else
                op.kind = KIND_CLEAR;
            if ($urandom_range(0, 99) < (op.kind == KIND_REMOVE ? 80 : 50))
                op.value = pool[$urandom_range(0, 7)];
            else
                op.value = $urandom;
            r = $urandom_range(0, 9);
            if (r == 0)
                op.position = '0;
            else if (r == 1)
                op.position = POS_W'($urandom_range(0, 31));
            else
                op.position = POS_W'($urandom_range(0, 16));
            op.drain = (i == 0 || $urandom_range(0, 199) == 0);
            pending_ops.push_back(op);
        end
        total_ops = pending_ops.size();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every transaction to be accepted and answered, then let the block settle.
        while (accepted_cnt < total_ops || expected_results.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        $display("Ran %0d operations: %0d append, %0d insert, %0d remove, %0d clear.",
                 accepted_cnt, kind_cnt[KIND_APPEND], kind_cnt[KIND_INSERT],
                 kind_cnt[KIND_REMOVE], kind_cnt[KIND_CLEAR]);
        $display("Saw %0d refusals on a full list, %0d failed removals, peak length %0d.",
                 full_cnt, miss_cnt, max_len);
        if (err_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #8000000;
        $display("%0t: timeout with %0d of %0d transactions accepted, %0d results pending",
                 $time, accepted_cnt, total_ops, expected_results.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
